/* src/ffba_pkg.sv */
// Shared constants, codes and control types of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 24;
  localparam int LIMIT_W    = ADDR_W + 1;
  localparam int END_W      = ADDR_W + 2;
  localparam int SIZE_W     = 24;
  localparam int HDR_W      = 7;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [LIMIT_W-1:0] HEAP_CAP   = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [HDR_W-1:0]   HDR_RESET  = 7'd16;
  localparam logic [HDR_W-1:0]   HDR_MIN    = 7'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] bytes;
    logic              is_free;
  } ffba_entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit_hit;
    logic commit_append;
    logic set_ignored;
    logic set_unknown;
    logic load_out;
  } ffba_cmd_t;

  typedef struct packed {
    logic trivial;
    logic hit;
    logic miss;
    logic is_free_req;
    logic out_busy;
  } ffba_stat_t;

endpackage

`default_nettype wire

/* src/ffba_if.sv */
// Request and result channel interfaces of the first-fit block allocator.
`default_nettype none

interface ffba_in_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output action, output request_size, output address,
                  input ready);
  modport sink (input valid, input action, input request_size, input address,
                output ready);
endinterface

interface ffba_out_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [STAT_W-1:0] status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink (input valid, input result_address, input status, output ready);
endinterface

`default_nettype wire

/* src/ffba_ctrl.sv */
// Controller state machine that sequences accept, table scan, append and result hand-off.
`default_nettype none

module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffba_pkg::ffba_stat_t st,
  output ffba_pkg::ffba_cmd_t  cmd
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPEND = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (st.trivial) begin
          cmd.set_ignored = 1'b1;
          state_nxt       = S_FINISH;
        end else if (st.hit) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = S_FINISH;
        end else if (st.miss) begin
          if (st.is_free_req) begin
            cmd.set_unknown = 1'b1;
            state_nxt       = S_FINISH;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.commit_append = 1'b1;
        state_nxt         = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ffba_dp.sv */
// Datapath with the block table memory, heap break, configuration and result registers.
`default_nettype none

module ffba_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ffba_pkg::ffba_cmd_t                 cmd,
  output ffba_pkg::ffba_stat_t                st,
  input  logic                                in_action,
  input  logic [ffba_pkg::SIZE_W-1:0]         in_request_size,
  input  logic [ffba_pkg::ADDR_W-1:0]         in_address,
  input  logic                                cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ffba_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ffba_pkg::ADDR_W-1:0]         out_result_address,
  output logic [ffba_pkg::STAT_W-1:0]         out_status
);
  import ffba_pkg::*;

  ffba_entry_t mem [MAX_BLOCKS];

  logic [LIMIT_W-1:0] heap_limit_r;
  logic [HDR_W-1:0]   header_r;
  logic               act_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [CNT_W-1:0]   count_r;
  logic [LIMIT_W-1:0] break_r;
  logic [CNT_W-1:0]   issue_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               rd_vld_r;
  ffba_entry_t        rd_entry_r;
  logic [END_W-1:0]   end_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic [STAT_W-1:0]  res_stat_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [STAT_W-1:0]  out_stat_r;

  logic [HDR_W-1:0]   hdr_eff;
  logic [LIMIT_W-1:0] limit_now;
  logic [LIMIT_W-1:0] pay_addr;
  logic [LIMIT_W-1:0] app_addr;
  logic               issue_go;
  logic               top_free;
  logic               exhausted;
  logic               full;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  ffba_entry_t        mem_wdata;

  always_comb begin
    hdr_eff   = (header_r == '0) ? HDR_MIN : header_r;
    limit_now = (heap_limit_r > HEAP_CAP) ? HEAP_CAP : heap_limit_r;
    pay_addr  = LIMIT_W'(rd_entry_r.start) + LIMIT_W'(hdr_eff);
    app_addr  = break_r + LIMIT_W'(hdr_eff);
    issue_go  = cmd.scan && (issue_r < count_r);
    top_free  = ((CNT_W'(chk_idx_r) + CNT_W'(1)) == count_r);
    exhausted = (end_r > END_W'(limit_now));
    full      = (count_r == CNT_W'(MAX_BLOCKS));

    st.trivial     = (act_r == ACT_ALLOC) ? (size_r == '0) : (addr_r == '0);
    st.is_free_req = (act_r == ACT_FREE);
    st.miss        = !rd_vld_r && (issue_r == count_r);
    if (act_r == ACT_FREE) begin
      st.hit = rd_vld_r && (pay_addr == LIMIT_W'(addr_r));
    end else begin
      st.hit = rd_vld_r && rd_entry_r.is_free && (rd_entry_r.bytes >= size_r);
    end
    st.out_busy = out_valid_r && !out_ready;

    mem_we    = 1'b0;
    mem_waddr = chk_idx_r;
    mem_wdata = rd_entry_r;
    if (cmd.commit_hit) begin
      mem_we            = !(st.is_free_req && top_free);
      mem_wdata.is_free = st.is_free_req;
    end else if (cmd.commit_append) begin
      mem_we            = !exhausted && !full;
      mem_waddr         = count_r[IDX_W-1:0];
      mem_wdata.start   = break_r[ADDR_W-1:0];
      mem_wdata.bytes   = size_r;
      mem_wdata.is_free = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue_go) begin
      rd_entry_r <= mem[issue_r[IDX_W-1:0]];
      chk_idx_r  <= issue_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= HEAP_CAP;
      header_r     <= HDR_RESET;
      count_r      <= '0;
      break_r      <= '0;
      issue_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_HEAP_LIMIT:   heap_limit_r <= cfg_data;
          CFG_HEADER_BYTES: header_r     <= cfg_data[HDR_W-1:0];
          default:          heap_limit_r <= heap_limit_r;
        endcase
      end
      if (cmd.commit_hit && st.is_free_req && top_free) begin
        count_r <= count_r - CNT_W'(1);
        break_r <= LIMIT_W'(rd_entry_r.start);
      end else if (cmd.commit_append && !exhausted && !full) begin
        count_r <= count_r + CNT_W'(1);
        break_r <= end_r[LIMIT_W-1:0];
      end
      if (cmd.start) begin
        issue_r <= '0;
      end else if (issue_go) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      rd_vld_r <= issue_go;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_r <= END_W'(break_r) + END_W'(hdr_eff) + END_W'(size_r);
    if (cmd.start) begin
      act_r      <= in_action;
      size_r     <= in_request_size;
      addr_r     <= in_address;
      res_addr_r <= '0;
      res_stat_r <= STAT_DONE;
    end
    if (cmd.set_ignored) begin
      res_stat_r <= STAT_IGNORED;
    end
    if (cmd.set_unknown) begin
      res_stat_r <= STAT_UNKNOWN;
    end
    if (cmd.commit_hit && !st.is_free_req) begin
      res_addr_r <= pay_addr[ADDR_W-1:0];
    end
    if (cmd.commit_append) begin
      priority if (exhausted) begin
        res_stat_r <= STAT_EXHAUSTED;
      end else if (full) begin
        res_stat_r <= STAT_FULL;
      end else begin
        res_addr_r <= app_addr[ADDR_W-1:0];
      end
    end
    if (cmd.load_out) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_stat_r;

endmodule

`default_nettype wire

/* src/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: controller and datapath.
//
//   channel  direction  handshake         contents
//   in_if    sink       valid / ready     action, request_size, address
//   out_if   source     valid / ready     result_address, status
//   cfg_*    input      cfg_we only       cfg_idx selects heap_limit or header_bytes
//
// An appending allocate takes longest from the acceptance of its request to its loaded result.
// That time is set by the first-fit and free lookup scan, which reads one table entry
// per cycle through the single read port of the block table memory.
// Reset clears the block count and heap break; the table itself is not cleared.
// The next request is accepted in the cycle after a result is loaded, while that result
// may still wait on out_if; a stalled result holds the following one back.
`default_nettype none

module first_fit_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  ffba_in_if.sink                         in_if,
  ffba_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t st;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ffba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_action          (in_if.action),
    .in_request_size    (in_if.request_size),
    .in_address         (in_if.address),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_data           (cfg_data),
    .out_ready          (out_if.ready),
    .out_valid          (out_if.valid),
    .out_result_address (out_if.result_address),
    .out_status         (out_if.status)
  );

endmodule

`default_nettype wire

/* src/ffba_checker.sv */
// Port-level checker of the first-fit block allocator and its bind statement.
`default_nettype none

module ffba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffba_pkg::ADDR_W-1:0] out_result_address,
  input logic [ffba_pkg::STAT_W-1:0] out_status
);
  import ffba_pkg::*;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_result_address))
    else $error("result changed while stalled");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= STAT_UNKNOWN))
    else $error("undefined status code");

  a_failed_has_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_DONE) |-> (out_result_address == '0))
    else $error("address returned with a non-done status");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_result_address (out_if.result_address),
  .out_status         (out_if.status)
);

`default_nettype wire
